### rtl/core/lptw_pkg.sv
`timescale 1ns / 1ps

package lptw_pkg;

    // field widths
    localparam int RANGE_W   = 16;
    localparam int BEARING_W = 15;
    localparam int POSE_W    = 24;
    localparam int HEADING_W = 15;
    localparam int CM_W      = 15;

    // cordic datapath widths
    localparam int VEC_W     = 41;
    localparam int ANG_W     = 29;
    localparam int ATAN_W    = 26;
    localparam int ROUND_W   = VEC_W - 24;
    localparam int ATAN_LEN  = 24;

    // default number of rotation steps
    localparam int CORDIC_STAGES_DEF = 16;

    // angle units of 1/64 degree
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int ANGLE_BIAS   = 3 * FULL_TURN;
    localparam int ANG_FRAC_SH  = 14;

    // start vector scale: 0.4 times the inverse cordic gain, in 2^-24 units
    localparam logic [22:0] GAIN_SCALE = 23'd4075205;

    // floor(2n/5) by reciprocal multiplication
    localparam logic [18:0] RCP_TWO_FIFTHS = 19'd419431;
    localparam int          RCP_SHIFT      = 20;

    // register map
    localparam logic REG_MIN_RANGE = 1'b0;
    localparam logic REG_MAX_RANGE = 1'b1;
    localparam logic [15:0] MIN_RANGE_RST = 16'd520;
    localparam logic [15:0] MAX_RANGE_RST = 16'd10000;

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // fields carried alongside the rotation
    typedef struct packed {
        logic signed [POSE_W-1:0] pose_x;
        logic signed [POSE_W-1:0] pose_y;
        logic [BEARING_W-1:0]     bearing;
        logic [CM_W-1:0]          range_cm;
        logic [1:0]               quad;
    } lptw_side_t;

    // rotation vector and residual angle
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } lptw_vec_t;

    // arctangent of 2^-i in 2^-20 degree
    function automatic logic [ATAN_W-1:0] atan_coef(input int idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:       v = 26'd47185920;
            1:       v = 26'd27855475;
            2:       v = 26'd14718068;
            3:       v = 26'd7471121;
            4:       v = 26'd3750058;
            5:       v = 26'd1876857;
            6:       v = 26'd938658;
            7:       v = 26'd469357;
            8:       v = 26'd234682;
            9:       v = 26'd117342;
            10:      v = 26'd58671;
            11:      v = 26'd29335;
            12:      v = 26'd14668;
            13:      v = 26'd7334;
            14:      v = 26'd3667;
            15:      v = 26'd1833;
            16:      v = 26'd917;
            17:      v = 26'd458;
            18:      v = 26'd229;
            19:      v = 26'd115;
            20:      v = 26'd57;
            21:      v = 26'd29;
            22:      v = 26'd14;
            23:      v = 26'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/lptw_cfg.sv
`timescale 1ns / 1ps

module lptw_cfg
    import lptw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output logic [RANGE_W-1:0]  min_range,
    output logic [RANGE_W-1:0]  max_range
);

    logic [RANGE_W-1:0] min_range_reg;
    logic [RANGE_W-1:0] max_range_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg <= MIN_RANGE_RST;
            max_range_reg <= MAX_RANGE_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_MIN_RANGE: min_range_reg <= pwdata[RANGE_W-1:0];
                REG_MAX_RANGE: max_range_reg <= pwdata[RANGE_W-1:0];
                default:       min_range_reg <= min_range_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[2])
            REG_MIN_RANGE: prdata = {{(32-RANGE_W){1'b0}}, min_range_reg};
            REG_MAX_RANGE: prdata = {{(32-RANGE_W){1'b0}}, max_range_reg};
            default:       prdata = '0;
        endcase
    end

    assign min_range = min_range_reg;
    assign max_range = max_range_reg;

endmodule

### rtl/core/lptw_front.sv
`timescale 1ns / 1ps

module lptw_front
    import lptw_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [RANGE_W-1:0]          range_raw,
    input  logic [BEARING_W-1:0]        bearing,
    input  logic signed [POSE_W-1:0]    pose_x,
    input  logic signed [POSE_W-1:0]    pose_y,
    input  logic signed [HEADING_W-1:0] heading,
    input  logic [RANGE_W-1:0]          min_range,
    input  logic [RANGE_W-1:0]          max_range,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lptw_vec_t                   out_vec,
    output lptw_side_t                  out_side
);

    logic                    s1_vld_reg;
    logic signed [VEC_W-1:0] s1_x_reg;
    logic [BEARING_W-1:0]    s1_t_reg;
    lptw_side_t              s1_side_reg;
    logic                    s2_vld_reg;
    lptw_vec_t               s2_vec_reg;
    lptw_side_t              s2_side_reg;

    logic s1_rdy;
    logic s2_rdy;

    logic                    gate_pass;
    logic [38:0]             x0_prod;
    logic [34:0]             cm_prod;
    logic signed [17:0]      t_raw;
    logic [16:0]             t_pos;
    logic [16:0]             t_mod;
    lptw_side_t              s1_side_next;
    logic [14:0]             r_rest;
    logic [1:0]              r_quad;
    lptw_vec_t               s2_vec_next;
    lptw_side_t              s2_side_next;

    // stage handshake
    assign s2_rdy   = !s2_vld_reg || out_ready;
    assign s1_rdy   = !s1_vld_reg || s2_rdy;
    assign in_ready = s1_rdy;

    // stage 1: gate, start vector, range in 1/16 cm, angle reduction
    assign gate_pass = (range_raw > min_range) && (range_raw < max_range);
    assign x0_prod   = range_raw * GAIN_SCALE;
    assign cm_prod   = range_raw * RCP_TWO_FIFTHS;
    assign t_raw     = 18'(heading) + 18'(ANGLE_BIAS) - $signed({3'b000, bearing});
    assign t_pos     = t_raw[16:0];

    always_comb
    begin
        if (t_pos >= 17'(3 * FULL_TURN))
            t_mod = t_pos - 17'(3 * FULL_TURN);
        else if (t_pos >= 17'(2 * FULL_TURN))
            t_mod = t_pos - 17'(2 * FULL_TURN);
        else if (t_pos >= 17'(FULL_TURN))
            t_mod = t_pos - 17'(FULL_TURN);
        else
            t_mod = t_pos;
    end

    always_comb
    begin
        s1_side_next.pose_x   = pose_x;
        s1_side_next.pose_y   = pose_y;
        s1_side_next.bearing  = bearing;
        s1_side_next.range_cm = cm_prod[RCP_SHIFT +: CM_W];
        s1_side_next.quad     = QUAD_0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (s1_rdy)
            s1_vld_reg <= in_valid && gate_pass;
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
        begin
            s1_x_reg    <= $signed({2'b00, x0_prod});
            s1_t_reg    <= t_mod[BEARING_W-1:0];
            s1_side_reg <= s1_side_next;
        end
    end

    // stage 2: quadrant and rest angle
    always_comb
    begin
        if (s1_t_reg >= 15'(3 * QUARTER_TURN))
        begin
            r_quad = QUAD_3;
            r_rest = s1_t_reg - 15'(3 * QUARTER_TURN);
        end
        else if (s1_t_reg >= 15'(2 * QUARTER_TURN))
        begin
            r_quad = QUAD_2;
            r_rest = s1_t_reg - 15'(2 * QUARTER_TURN);
        end
        else if (s1_t_reg >= 15'(QUARTER_TURN))
        begin
            r_quad = QUAD_1;
            r_rest = s1_t_reg - 15'(QUARTER_TURN);
        end
        else
        begin
            r_quad = QUAD_0;
            r_rest = s1_t_reg;
        end
    end

    always_comb
    begin
        s2_vec_next.x      = s1_x_reg;
        s2_vec_next.y      = '0;
        s2_vec_next.z      = {2'b00, r_rest[12:0], {ANG_FRAC_SH{1'b0}}};
        s2_side_next       = s1_side_reg;
        s2_side_next.quad  = r_quad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (s2_rdy)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_rdy)
        begin
            s2_vec_reg  <= s2_vec_next;
            s2_side_reg <= s2_side_next;
        end
    end

    assign out_valid = s2_vld_reg;
    assign out_vec   = s2_vec_reg;
    assign out_side  = s2_side_reg;

endmodule

### rtl/core/lptw_cordic.sv
`timescale 1ns / 1ps

module lptw_cordic
    import lptw_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lptw_vec_t  in_vec,
    input  lptw_side_t in_side,
    output logic       out_valid,
    input  logic       out_ready,
    output lptw_vec_t  out_vec,
    output lptw_side_t out_side
);

    logic       vld_reg  [0:CORDIC_STAGES-1];
    lptw_vec_t  vec_reg  [0:CORDIC_STAGES-1];
    lptw_side_t side_reg [0:CORDIC_STAGES-1];

    logic       stg_vld  [0:CORDIC_STAGES];
    lptw_vec_t  stg_vec  [0:CORDIC_STAGES];
    lptw_side_t stg_side [0:CORDIC_STAGES];
    logic       rdy      [0:CORDIC_STAGES];

    assign stg_vld[0]  = in_valid;
    assign stg_vec[0]  = in_vec;
    assign stg_side[0] = in_side;
    assign rdy[CORDIC_STAGES] = out_ready;
    assign in_ready = rdy[0];

    // one micro-rotation per register stage
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_step
        lptw_vec_t               vec_next;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        logic signed [ANG_W-1:0] da;

        assign rdy[g] = !vld_reg[g] || rdy[g+1];

        assign dx = stg_vec[g].y >>> g;
        assign dy = stg_vec[g].x >>> g;
        assign da = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_coef(g)});

        // rotate towards zero residual angle
        always_comb
        begin
            if (!stg_vec[g].z[ANG_W-1])
            begin
                vec_next.x = stg_vec[g].x - dx;
                vec_next.y = stg_vec[g].y + dy;
                vec_next.z = stg_vec[g].z - da;
            end
            else
            begin
                vec_next.x = stg_vec[g].x + dx;
                vec_next.y = stg_vec[g].y - dy;
                vec_next.z = stg_vec[g].z + da;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (rdy[g])
                vld_reg[g] <= stg_vld[g];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[g])
            begin
                vec_reg[g]  <= vec_next;
                side_reg[g] <= stg_side[g];
            end
        end

        assign stg_vld[g+1]  = vld_reg[g];
        assign stg_vec[g+1]  = vec_reg[g];
        assign stg_side[g+1] = side_reg[g];
    end

    assign out_valid = stg_vld[CORDIC_STAGES];
    assign out_vec   = stg_vec[CORDIC_STAGES];
    assign out_side  = stg_side[CORDIC_STAGES];

endmodule

### rtl/core/lptw_back.sv
`timescale 1ns / 1ps

module lptw_back
    import lptw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  lptw_vec_t                in_vec,
    input  lptw_side_t               in_side,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [POSE_W-1:0] world_x,
    output logic signed [POSE_W-1:0] world_y,
    output logic [BEARING_W-1:0]     bearing_out,
    output logic [CM_W-1:0]          range_cm
);

    logic                      b1_vld_reg;
    logic signed [ROUND_W-1:0] b1_c_reg;
    logic signed [ROUND_W-1:0] b1_s_reg;
    lptw_side_t                b1_side_reg;
    logic                      b2_vld_reg;
    logic signed [POSE_W-1:0]  b2_x_reg;
    logic signed [POSE_W-1:0]  b2_y_reg;
    logic [BEARING_W-1:0]      b2_bearing_reg;
    logic [CM_W-1:0]           b2_cm_reg;

    logic b1_rdy;
    logic b2_rdy;

    logic signed [VEC_W-1:0]   c_full;
    logic signed [VEC_W-1:0]   s_full;
    logic signed [VEC_W-1:0]   c_bias;
    logic signed [VEC_W-1:0]   s_bias;
    logic signed [POSE_W:0]    wx_sum;
    logic signed [POSE_W:0]    wy_sum;
    logic signed [POSE_W-1:0]  wx_sat;
    logic signed [POSE_W-1:0]  wy_sat;

    assign b2_rdy   = !b2_vld_reg || out_ready;
    assign b1_rdy   = !b1_vld_reg || b2_rdy;
    assign in_ready = b1_rdy;

    // stage b1: exact quarter-turn rotation and rounding to 1/16 cm
    always_comb
    begin
        case (in_side.quad)
            QUAD_0:
            begin
                c_full = in_vec.x;
                s_full = in_vec.y;
            end
            QUAD_1:
            begin
                c_full = -in_vec.y;
                s_full = in_vec.x;
            end
            QUAD_2:
            begin
                c_full = -in_vec.x;
                s_full = -in_vec.y;
            end
            QUAD_3:
            begin
                c_full = in_vec.y;
                s_full = -in_vec.x;
            end
            default:
            begin
                c_full = in_vec.x;
                s_full = in_vec.y;
            end
        endcase
    end

    assign c_bias = c_full + $signed(VEC_W'(1) << 23);
    assign s_bias = s_full + $signed(VEC_W'(1) << 23);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b1_vld_reg <= 1'b0;
        else if (b1_rdy)
            b1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (b1_rdy)
        begin
            b1_c_reg    <= c_bias[VEC_W-1:24];
            b1_s_reg    <= s_bias[VEC_W-1:24];
            b1_side_reg <= in_side;
        end
    end

    // stage b2: add pose and saturate, output register
    assign wx_sum = {b1_side_reg.pose_x[POSE_W-1], b1_side_reg.pose_x}
                    + (POSE_W+1)'(b1_c_reg);
    assign wy_sum = {b1_side_reg.pose_y[POSE_W-1], b1_side_reg.pose_y}
                    + (POSE_W+1)'(b1_s_reg);

    always_comb
    begin
        if (wx_sum[POSE_W] != wx_sum[POSE_W-1])
            wx_sat = wx_sum[POSE_W] ? {1'b1, {(POSE_W-1){1'b0}}} : {1'b0, {(POSE_W-1){1'b1}}};
        else
            wx_sat = wx_sum[POSE_W-1:0];
        if (wy_sum[POSE_W] != wy_sum[POSE_W-1])
            wy_sat = wy_sum[POSE_W] ? {1'b1, {(POSE_W-1){1'b0}}} : {1'b0, {(POSE_W-1){1'b1}}};
        else
            wy_sat = wy_sum[POSE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b2_vld_reg <= 1'b0;
        else if (b2_rdy)
            b2_vld_reg <= b1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b2_rdy)
        begin
            b2_x_reg       <= wx_sat;
            b2_y_reg       <= wy_sat;
            b2_bearing_reg <= b1_side_reg.bearing;
            b2_cm_reg      <= b1_side_reg.range_cm;
        end
    end

    assign out_valid   = b2_vld_reg;
    assign world_x     = b2_x_reg;
    assign world_y     = b2_y_reg;
    assign bearing_out = b2_bearing_reg;
    assign range_cm    = b2_cm_reg;

endmodule

### rtl/core/lidar_point_to_world_transform_unit.sv
`timescale 1ns / 1ps

// lidar return to world point transform
// input stream (s_*): one lidar return with the robot pose per transfer;
// returns whose range lies strictly between min_range and max_range give
// one world point on the output stream (m_*), all others give nothing.
// config port (apb): min_range at 0x0, max_range at 0x4, write only while idle.
// pipeline from input transfer to m_tvalid: two front stages for gating, start
// vector and angle reduction, one stage per rotation step (16 by default),
// then one stage for quadrant rotation and rounding and one output register.
// throughput: one return per cycle while m_tready is high, set by the
// single register per stage.
// every stage keeps its own valid bit; when the receiver holds m_tready low
// the output register holds its point and earlier stages keep filling any
// empty slots, so s_tready drops only once the whole pipeline is full.
// reset clears all valid bits and loads min_range 520, max_range 10000.

module lidar_point_to_world_transform_unit
    import lptw_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // range_raw[15:0], bearing[30:16], pose_x[54:31], pose_y[78:55],
    // heading[93:79], zero [95:94]
    input  logic [95:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // world_x[23:0], world_y[47:24], bearing_out[62:48], range_cm[77:63],
    // zero [79:78]
    output logic [79:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [RANGE_W-1:0]          min_range;
    logic [RANGE_W-1:0]          max_range;
    logic signed [POSE_W-1:0]    world_x;
    logic signed [POSE_W-1:0]    world_y;
    logic [BEARING_W-1:0]        bearing_out;
    logic [CM_W-1:0]             range_cm;

    logic       fr_valid;
    logic       fr_ready;
    lptw_vec_t  fr_vec;
    lptw_side_t fr_side;
    logic       cr_valid;
    logic       cr_ready;
    lptw_vec_t  cr_vec;
    lptw_side_t cr_side;

    // configuration registers
    lptw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .min_range (min_range),
        .max_range (max_range)
    );

    // gating and angle reduction
    lptw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .range_raw (s_tdata[15:0]),
        .bearing   (s_tdata[30:16]),
        .pose_x    (s_tdata[54:31]),
        .pose_y    (s_tdata[78:55]),
        .heading   (s_tdata[93:79]),
        .min_range (min_range),
        .max_range (max_range),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_vec   (fr_vec),
        .out_side  (fr_side)
    );

    // rotation pipeline
    lptw_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_vec    (fr_vec),
        .in_side   (fr_side),
        .out_valid (cr_valid),
        .out_ready (cr_ready),
        .out_vec   (cr_vec),
        .out_side  (cr_side)
    );

    // quadrant, rounding, pose offset and output register
    lptw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cr_valid),
        .in_ready    (cr_ready),
        .in_vec      (cr_vec),
        .in_side     (cr_side),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .world_x     (world_x),
        .world_y     (world_y),
        .bearing_out (bearing_out),
        .range_cm    (range_cm)
    );

    assign m_tdata = {2'b00, range_cm, bearing_out, world_y, world_x};

endmodule

### sim/lptw_point_checker.sv
`timescale 1ns / 1ps

module lptw_point_checker
    import lptw_pkg::*;
#(
    parameter int ROT_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // range_raw[15:0], bearing[30:16], pose_x[54:31], pose_y[78:55], heading[93:79]
    input  logic [95:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // world_x[23:0], world_y[47:24], bearing_out[62:48], range_cm[77:63]
    input  logic [79:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          points_due
);

    // angle units of 1/64 degree, residual angle in 2^-20 degree
    localparam longint TURN_UNITS    = 23040;
    localparam longint QUARTER_UNITS = 5760;
    localparam longint TURN_OFFSET   = 3 * TURN_UNITS;
    localparam longint START_GAIN    = 4075205;
    localparam longint ROUND_HALF    = 64'sd1 <<< 23;
    localparam longint WORLD_MAX     = 8388607;
    localparam longint WORLD_MIN     = -8388608;
    localparam int     ARCTAN_LEN    = 24;

    typedef struct packed {
        logic signed [23:0] world_x;
        logic signed [23:0] world_y;
        logic [14:0]        bearing_out;
        logic [14:0]        range_cm;
    } world_point_t;

    // arctangent of 2^-i, 2^-20 degree, rounded
    longint arctan_units [ARCTAN_LEN] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    logic [15:0]  min_gate;
    logic [15:0]  max_gate;
    world_point_t due_points [$];
    int           faults;

    // gate the return and rotate it into the world frame
    function automatic bit predict_point(input logic [95:0] word, output world_point_t pt);
        logic [15:0]        rng;
        logic [14:0]        brg;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [14:0] hd;
        longint             ang;
        longint             quad;
        longint             zr;
        longint             vx;
        longint             vy;
        longint             dx;
        longint             dy;
        longint             cx;
        longint             sy;
        longint             wx;
        longint             wy;
        rng = word[15:0];
        brg = word[30:16];
        px  = word[54:31];
        py  = word[78:55];
        hd  = word[93:79];
        pt  = '0;
        if (!(rng > min_gate && rng < max_gate))
            return 1'b0;

        // angle reduced into one turn, split into quadrant and rest
        ang  = (longint'(hd) - longint'(brg) + TURN_OFFSET) % TURN_UNITS;
        quad = ang / QUARTER_UNITS;
        zr   = (ang % QUARTER_UNITS) * 16384;

        // rotation steps with floor shifts
        vx = longint'(rng) * START_GAIN;
        vy = 0;
        for (int i = 0; i < ROT_STEPS && i < ARCTAN_LEN; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (zr >= 0)
            begin
                vx = vx - dx;
                vy = vy + dy;
                zr = zr - arctan_units[i];
            end
            else
            begin
                vx = vx + dx;
                vy = vy - dy;
                zr = zr + arctan_units[i];
            end
        end

        // exact quarter turns
        case (quad)
            1:       begin cx = -vy; sy = vx;  end
            2:       begin cx = -vx; sy = -vy; end
            3:       begin cx = vy;  sy = -vx; end
            default: begin cx = vx;  sy = vy;  end
        endcase

        // round to 1/16 cm, add the pose and saturate
        wx = longint'(px) + ((cx + ROUND_HALF) >>> 24);
        wy = longint'(py) + ((sy + ROUND_HALF) >>> 24);
        if (wx > WORLD_MAX)
            wx = WORLD_MAX;
        else if (wx < WORLD_MIN)
            wx = WORLD_MIN;
        if (wy > WORLD_MAX)
            wy = WORLD_MAX;
        else if (wy < WORLD_MIN)
            wy = WORLD_MIN;

        pt.world_x     = wx[23:0];
        pt.world_y     = wy[23:0];
        pt.bearing_out = brg;
        pt.range_cm    = 15'(((longint'(rng) * 2) / 5) & 64'h7FFF);
        return 1'b1;
    endfunction

    // count a field that disagrees, report the first few
    task automatic note_field(input string what, input longint want, input longint got);
        if (want != got)
        begin
            faults++;
            if (faults <= 10)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // watch the three ports
    always @(posedge clk or negedge rst_n)
    begin : watch
        world_point_t pt;
        world_point_t oldest;
        if (!rst_n)
        begin
            min_gate = 16'd520;
            max_gate = 16'd10000;
            due_points.delete();
            faults = 0;
            mismatch_count <= 0;
            points_due     <= 0;
        end
        else
        begin
            // input transfer
            if (s_tvalid && s_tready)
            begin
                if (predict_point(s_tdata, pt))
                    due_points = {due_points, pt};
            end

            // output transfer
            if (m_tvalid && m_tready)
            begin
                if (due_points.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t ns: point with none due, data %h", $time, m_tdata);
                end
                else
                begin
                    oldest = due_points.pop_front();
                    note_field("world_x", oldest.world_x, $signed(m_tdata[23:0]));
                    note_field("world_y", oldest.world_y, $signed(m_tdata[47:24]));
                    note_field("bearing_out", oldest.bearing_out, m_tdata[62:48]);
                    note_field("range_cm", oldest.range_cm, m_tdata[77:63]);
                end
            end

            // register write
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_MIN_RANGE)
                    min_gate = pwdata[15:0];
                else
                    max_gate = pwdata[15:0];
            end

            mismatch_count <= faults;
            points_due     <= due_points.size();
        end
    end

endmodule

### sim/tb_lidar_point_to_world_transform_unit.sv
`timescale 1ns / 1ps

module tb_lidar_point_to_world_transform_unit;
    import lptw_pkg::*;

    localparam int         ROT_STEPS      = 16;
    localparam int         SETTLE_CYCLES  = ROT_STEPS + 8;
    localparam int         PHASE_COUNT    = 9;
    localparam int         PHASE_RETURNS  = 205;
    localparam logic [2:0] ADDR_MIN_RANGE = {REG_MIN_RANGE, 2'b00};
    localparam logic [2:0] ADDR_MAX_RANGE = {REG_MAX_RANGE, 2'b00};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic [95:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatch_count;
    int          points_due;
    int          tx_idle_pct = 8;
    int          rx_idle_pct = 51;

    lidar_point_to_world_transform_unit #(
        .CORDIC_STAGES(ROT_STEPS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lptw_point_checker #(
        .ROT_STEPS(ROT_STEPS)
    ) point_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .points_due     (points_due)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    function automatic logic [95:0] pack_return(input logic [15:0] rng, input logic [14:0] brg,
                                                input logic [23:0] px, input logic [23:0] py,
                                                input logic [14:0] hd);
        return {2'b00, hd, py, px, brg, rng};
    endfunction

    // random return, ranges mostly inside or on the edges of the gate
    function automatic logic [95:0] random_return(input logic [15:0] lo, input logic [15:0] hi);
        logic [15:0] rng;
        logic [14:0] brg;
        logic [23:0] pos [2];
        logic [14:0] hd;
        case ($urandom_range(0, 7))
            0:       rng = 16'($urandom);
            1:       rng = 16'(lo + $urandom_range(0, 2) - 1);
            2:       rng = 16'(hi + $urandom_range(0, 2) - 1);
            default: rng = (hi > lo + 1) ? 16'(lo + 1 + $urandom_range(0, hi - lo - 2))
                                         : 16'($urandom);
        endcase
        brg = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23039));
        hd  = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23040) - 11520);
        for (int k = 0; k < 2; k++)
        begin
            case ($urandom_range(0, 3))
                0:       pos[k] = 24'($urandom);
                1:       pos[k] = 24'(8388607 - $urandom_range(0, 30000));
                2:       pos[k] = 24'(-8388608 + $urandom_range(0, 30000));
                default: pos[k] = 24'($urandom_range(0, 2000) - 1000);
            endcase
        end
        return pack_return(rng, brg, pos[0], pos[1], hd);
    endfunction

    // one input transfer, with random gaps before it
    task automatic push_return(input logic [95:0] word);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // apb write: setup, access, release
    task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_gate(input logic [15:0] lo, input logic [15:0] hi);
        write_reg(ADDR_MIN_RANGE, lo);
        write_reg(ADDR_MAX_RANGE, hi);
    endtask

    // wait for every due point, then for returns still in flight
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (points_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] lo;
        logic [15:0] hi;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // gate edges at the reset limits
        push_return(pack_return(16'd520, 15'd0, 24'd0, 24'd0, 15'd0));
        push_return(pack_return(16'd521, 15'd0, 24'd0, 24'd0, 15'd0));
        push_return(pack_return(16'd9999, 15'd0, 24'd0, 24'd0, 15'd0));
        push_return(pack_return(16'd10000, 15'd0, 24'd0, 24'd0, 15'd0));
        drain_pipeline();

        // widest gate: range extremes, quadrant boundaries, angle wrap, saturation
        set_gate(16'd0, 16'hFFFF);
        push_return(pack_return(16'd0, 15'd100, 24'd0, 24'd0, 15'd0));
        push_return(pack_return(16'hFFFF, 15'd100, 24'd0, 24'd0, 15'd0));
        push_return(pack_return(16'd1, 15'd23039, 24'd0, 24'd0, -15'sd11520));
        push_return(pack_return(16'hFFFE, 15'd0, 24'd0, 24'd0, 15'd0));
        push_return(pack_return(16'hFFFE, 15'd0, 24'd0, 24'd0, 15'd5760));
        push_return(pack_return(16'hFFFE, 15'd0, 24'd0, 24'd0, 15'd11520));
        push_return(pack_return(16'hFFFE, 15'd0, 24'd0, 24'd0, -15'sd5760));
        push_return(pack_return(16'hFFFE, 15'd5760, 24'd0, 24'd0, 15'd0));
        push_return(pack_return(16'd40000, 15'd0, 24'd1234, -24'sd999, 15'd2880));
        push_return(pack_return(16'd30000, 15'h7FFF, 24'd0, 24'd0, 15'd16383));
        push_return(pack_return(16'd30000, 15'd17, 24'd0, 24'd0, -15'sd16384));
        push_return(pack_return(16'hFFFE, 15'd0, 24'h7FFFFF, 24'd0, 15'd0));
        push_return(pack_return(16'hFFFE, 15'd0, 24'h800000, 24'd0, 15'd11520));
        push_return(pack_return(16'hFFFE, 15'd0, 24'd0, 24'h7FFFFF, 15'd5760));
        push_return(pack_return(16'hFFFE, 15'd0, 24'd0, 24'h800000, -15'sd5760));
        push_return(pack_return(16'hFFFE, 15'd0, 24'h7FFFFF, 24'h800000, 15'd2880));
        drain_pipeline();

        // empty gates: equal limits, then crossed limits
        set_gate(16'd5000, 16'd5000);
        push_return(pack_return(16'd5000, 15'd0, 24'd0, 24'd0, 15'd0));
        push_return(pack_return(16'd5001, 15'd0, 24'd0, 24'd0, 15'd0));
        drain_pipeline();
        set_gate(16'd60000, 16'd100);
        push_return(pack_return(16'd3000, 15'd0, 24'd0, 24'd0, 15'd0));
        push_return(pack_return(16'd60001, 15'd0, 24'd0, 24'd0, 15'd0));

        // random phases, each with a gate and idling set for that phase
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0, 4, 8: begin lo = 16'd0;     hi = 16'hFFFF;  end
                1:       begin lo = 16'd520;   hi = 16'd10000; end
                3:       begin lo = 16'd30000; hi = 16'd30000; end
                6:       begin lo = 16'hFFFF;  hi = 16'd0;     end
                default:
                begin
                    lo = 16'($urandom_range(0, 30000));
                    hi = 16'(lo + $urandom_range(2, 35000));
                end
            endcase
            drain_pipeline();
            if (ph < 3)
            begin
                tx_idle_pct = 8;
                rx_idle_pct = 51;
            end
            else if (ph < 6)
            begin
                tx_idle_pct = 51;
                rx_idle_pct = 8;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            set_gate(lo, hi);
            repeat (PHASE_RETURNS)
                push_return(random_return(lo, hi));
        end

        drain_pipeline();
        if (mismatch_count == 0 && points_due == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/lptw_pkg.sv
rtl/core/lptw_cfg.sv
rtl/core/lptw_front.sv
rtl/core/lptw_cordic.sv
rtl/core/lptw_back.sv
rtl/core/lidar_point_to_world_transform_unit.sv
sim/lptw_point_checker.sv
sim/tb_lidar_point_to_world_transform_unit.sv
